// File: src/sqd_pkg.sv
`default_nettype none
package sqd_pkg;
  localparam logic [1:0] EV_JOIN   = 2'd0;
  localparam logic [1:0] EV_LOST   = 2'd1;
  localparam logic [1:0] EV_FINISH = 2'd2;
  localparam logic [1:0] EV_START  = 2'd3;

  localparam logic [1:0] REG_ACTIVE_LINES = 2'd0;
  localparam logic [1:0] REG_MAX_LENGTH   = 2'd1;
  localparam logic [1:0] REG_SERVICE_LOW  = 2'd2;
  localparam logic [1:0] REG_SERVICE_HIGH = 2'd3;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [2:0]  line;
    logic [4:0]  length;
    logic [15:0] wait_ticks;
    logic [31:0] tick;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [3:0]  arrivals;
    logic [31:0] tick;
  } job_t;
endpackage
`default_nettype wire

// File: src/sqd_front.sv
`default_nettype none
module sqd_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  wire [3:0]        in_arrivals,
  output logic             job_valid,
  input  wire              job_ready,
  output sqd_pkg::job_t    job
);
  localparam int QD = 2;
  sqd_pkg::job_t q_r [QD];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  logic [31:0] tick_r;
  logic push, pop;

  assign in_tready = (cnt_r != 2'(QD));
  assign push = in_tvalid && in_tready;
  assign job_valid = (cnt_r != 2'd0);
  assign pop = job_valid && job_ready;
  assign job = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{arrivals: in_arrivals, tick: tick_r};
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
      tick_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
        tick_r <= tick_r + 32'd1;
      end
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// File: src/sqd_back.sv
`default_nettype none
module sqd_back #(
  parameter int MAX_LINES = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                job_valid,
  output logic               job_ready,
  input  sqd_pkg::job_t      job,
  input  wire [3:0]          active_lines,
  input  wire [4:0]          max_line_length,
  input  wire [63:0]         service_times,
  output logic               res_valid,
  input  wire                res_ready,
  output sqd_pkg::result_t   res
);
  localparam int LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int DW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ARR  = 3'd1;
  localparam logic [2:0] ST_SRV  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [31:0] stamps [2 ** (LW + DW)];
  logic [DW-1:0] heads_r [MAX_LINES];
  logic [CW-1:0] counts_r [MAX_LINES];
  logic [7:0] cd_r [MAX_LINES];

  logic [2:0] st_r;
  logic [3:0] left_r;
  logic [31:0] tick_r;
  logic [3:0] lines;
  logic [CW:0] limit;
  logic [LW-1:0] j_r;
  logic phase_r;
  logic [31:0] rd_r;
  logic [LW-1:0] best;
  logic [CW-1:0] bcnt;
  sqd_pkg::result_t out_r, stg_r;
  logic out_v_r, stg_v_r, emit_ok;
  logic [31:0] diff;
  logic [7:0] svc;
  logic [DW:0] wsum;
  logic [LW+DW-1:0] waddr, raddr;

  assign lines = (active_lines > 4'(MAX_LINES)) ? 4'(MAX_LINES) : active_lines;
  assign limit = ({1'b0, max_line_length} > (CW+1)'(QUEUE_DEPTH)) ?
                 (CW+1)'(QUEUE_DEPTH) : (CW+1)'(max_line_length);
  assign job_ready = (st_r == ST_IDLE);
  assign res_valid = out_v_r;
  assign res = out_r;
  assign emit_ok = !stg_v_r || !out_v_r;
  assign diff = tick_r - rd_r;
  assign svc = service_times[8*j_r +: 8];
  assign wsum = {1'b0, heads_r[best]} + (DW+1)'(counts_r[best]);
  assign waddr = {best, (wsum >= (DW+1)'(QUEUE_DEPTH)) ?
                 DW'(wsum - (DW+1)'(QUEUE_DEPTH)) : wsum[DW-1:0]};
  assign raddr = {j_r, heads_r[j_r]};

  always_comb begin
    best = '0;
    bcnt = counts_r[0];
    for (int k = 1; k < MAX_LINES; k++) begin
      if (4'(k) < lines && counts_r[k] < bcnt) begin
        best = LW'(k);
        bcnt = counts_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_ARR && emit_ok && left_r != 0 && {1'b0, bcnt} < limit) begin
      stamps[waddr] <= tick_r;
    end
    rd_r <= stamps[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      out_v_r <= 1'b0;
      stg_v_r <= 1'b0;
      for (int k = 0; k < MAX_LINES; k++) begin
        heads_r[k] <= '0;
        counts_r[k] <= '0;
        cd_r[k] <= '0;
      end
    end else begin
      if (out_v_r && res_ready) out_v_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (job_valid) begin
            tick_r <= job.tick;
            left_r <= (lines == 0) ? 4'd0 : job.arrivals;
            j_r <= '0;
            phase_r <= 1'b0;
            st_r <= ST_ARR;
          end
        end
        ST_ARR: begin
          if (emit_ok) begin
            if (left_r != 0) begin
              left_r <= left_r - 4'd1;
              if (stg_v_r) begin
                out_r <= stg_r;
                out_v_r <= 1'b1;
              end
              stg_v_r <= 1'b1;
              stg_r.wait_ticks <= '0;
              stg_r.tick <= tick_r;
              stg_r.last <= 1'b0;
              if ({1'b0, bcnt} < limit) begin
                counts_r[best] <= bcnt + 1'b1;
                stg_r.event_res <= sqd_pkg::EV_JOIN;
                stg_r.line <= 3'(best);
                stg_r.length <= 5'(bcnt + 1'b1);
              end else begin
                stg_r.event_res <= sqd_pkg::EV_LOST;
                stg_r.line <= '0;
                stg_r.length <= '0;
              end
            end else begin
              st_r <= (lines == 0) ? ST_OUT : ST_SRV;
            end
          end
        end
        ST_SRV: begin
          if (emit_ok) begin
            if (!phase_r) begin
              phase_r <= 1'b1;
              if (cd_r[j_r] != 0) begin
                cd_r[j_r] <= cd_r[j_r] - 8'd1;
                if (cd_r[j_r] == 8'd1) begin
                  if (stg_v_r) begin
                    out_r <= stg_r;
                    out_v_r <= 1'b1;
                  end
                  stg_v_r <= 1'b1;
                  stg_r <= '{event_res: sqd_pkg::EV_FINISH, line: 3'(j_r),
                             length: 5'(counts_r[j_r]), wait_ticks: '0,
                             tick: tick_r, last: 1'b0};
                end
              end
            end else if (counts_r[j_r] != 0 && cd_r[j_r] == 0) begin
              st_r <= ST_RD;
            end else begin
              phase_r <= 1'b0;
              if (4'(j_r) + 4'd1 >= lines) st_r <= ST_OUT;
              else j_r <= j_r + 1'b1;
            end
          end
        end
        ST_RD: begin
          cd_r[j_r] <= svc;
          heads_r[j_r] <= (heads_r[j_r] == DW'(QUEUE_DEPTH - 1)) ? '0 :
                          heads_r[j_r] + 1'b1;
          counts_r[j_r] <= counts_r[j_r] - 1'b1;
          if (stg_v_r) begin
            out_r <= stg_r;
            out_v_r <= 1'b1;
          end
          stg_v_r <= 1'b1;
          stg_r <= '{event_res: sqd_pkg::EV_START, line: 3'(j_r),
                     length: 5'(counts_r[j_r] - 1'b1),
                     wait_ticks: (diff > 32'hFFFF) ? 16'hFFFF : diff[15:0],
                     tick: tick_r, last: 1'b0};
          phase_r <= 1'b0;
          if (4'(j_r) + 4'd1 >= lines) begin
            st_r <= ST_OUT;
          end else begin
            st_r <= ST_SRV;
            j_r <= j_r + 1'b1;
          end
        end
        ST_OUT: begin
          if (stg_v_r) begin
            if (!out_v_r) begin
              out_v_r <= 1'b1;
              stg_v_r <= 1'b0;
              out_r <= '{event_res: stg_r.event_res, line: stg_r.line,
                         length: stg_r.length, wait_ticks: stg_r.wait_ticks,
                         tick: stg_r.tick, last: 1'b1};
              st_r <= ST_IDLE;
            end
          end else begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: src/shortest_queue_dispatcher.sv
// Join-shortest-queue dispatcher.
// The in_ channel carries one tick per transfer, its arrival count in tdata.
// Each tick yields up to 15 + 2 * MAX_LINES result transfers on the out_
// channel, in order: one per arrival (joined or lost), then per line a
// service finish and a service start. tlast marks the final result of a
// tick; a tick with no events gives no transfer but still advances the count.
// Configuration must be written on the cfg_ channel while the block is idle;
// the block itself does not enforce this. A tick's transfer enters the front
// queue and the back end takes it when idle; each result then waits in a
// staging register so that tlast can be set on the final one. A new result
// is made only while the staging register or the result register is free.
// A tick occupies the back end sequencer while it steps through its
// arrivals and then each active line in turn. A two-entry queue sits between
// the front and back, so ticks are taken while results wait.
// A stalled receiver holds the result register; the back end waits on it.
// Reset empties all queues, servers and the tick count, sets active lines
// to 8 and the length limit to 16, and clears service times.
// Enqueue stamps live in a memory that needs no clearing.
`default_nettype none
module shortest_queue_dispatcher #(
  parameter int MAX_LINES = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [7:0]   in_tdata,   // arrivals[3:0], zero fill
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,  // event_res, line, length, wait_ticks, tick, zero fill
  output logic        out_tlast,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [1:0]   cfg_index,
  input  wire [31:0]  cfg_data
);
  logic [3:0] act_r;
  logic [4:0] maxl_r;
  logic [63:0] svc_r;
  logic job_valid, job_ready;
  sqd_pkg::job_t job;
  sqd_pkg::result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 4'd8;
      maxl_r <= 5'd16;
      svc_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sqd_pkg::REG_ACTIVE_LINES: act_r <= cfg_data[3:0];
        sqd_pkg::REG_MAX_LENGTH:   maxl_r <= cfg_data[4:0];
        sqd_pkg::REG_SERVICE_LOW:  svc_r[31:0] <= cfg_data;
        sqd_pkg::REG_SERVICE_HIGH: svc_r[63:32] <= cfg_data;
        default: ;
      endcase
    end
  end

  sqd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_arrivals(in_tdata[3:0]), .job_valid(job_valid), .job_ready(job_ready),
    .job(job)
  );

  sqd_back #(.MAX_LINES(MAX_LINES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready),
    .job(job), .active_lines(act_r), .max_line_length(maxl_r),
    .service_times(svc_r), .res_valid(out_tvalid), .res_ready(out_tready),
    .res(res)
  );

  assign out_tdata = {6'b0, res.tick, res.wait_ticks, res.length, res.line,
                      res.event_res};
  assign out_tlast = res.last;

  a_lost_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == sqd_pkg::EV_LOST |-> out_tdata[9:2] == 8'd0)
    else $error("lost arrival with line or length set");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[9:5] <= 5'd16)
    else $error("queue length out of range");
  a_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != sqd_pkg::EV_START |-> out_tdata[25:10] == 16'd0)
    else $error("wait reported on non-start event");
endmodule
`default_nettype wire
